FILE: hdl/dmwc_pkg.sv
// ----------------------------------------------------------------------------
// dmwc_pkg
// Shared types and geometry of the direct-mapped write-back byte cache.
// ----------------------------------------------------------------------------
package dmwc_pkg;

    localparam int LINE_BYTES  = 8;
    localparam int NUM_LINES   = 32;
    localparam int ADDR_BITS   = 16;
    localparam int DATA_BITS   = 8;

    localparam int OFF_BITS    = $clog2(LINE_BYTES);
    localparam int IDX_BITS    = $clog2(NUM_LINES);
    localparam int TAG_BITS    = ADDR_BITS - OFF_BITS - IDX_BITS;
    localparam int CACHE_DEPTH = LINE_BYTES * NUM_LINES;
    localparam int CACHE_AW    = OFF_BITS + IDX_BITS;
    localparam int STORE_DEPTH = 1 << ADDR_BITS;
    localparam int CNT_BITS    = OFF_BITS + 1;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [ADDR_BITS-1:0] address;
        logic [DATA_BITS-1:0] data;
    } req_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_byte;
        logic                 hit;
        logic                 line_dirty;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_READ,
        S_EVICT,
        S_FILL
    } state_t;

endpackage

FILE: hdl/direct_mapped_writeback_cache_core.sv
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_core
// Direct-mapped write-back write-allocate byte cache over a byte-wide store.
// ----------------------------------------------------------------------------
// A read hit passes through LOOKUP and READ; a write hit returns to idle from
// LOOKUP. A miss refills the line from the store in FILL, and a dirty victim
// is first written back in EVICT; a read miss gives its result as FILL ends.
// Byte-wide memory ports set the miss cost. After reset the core sweeps both
// memories to zero, one byte per cycle, over all 2^ADDR_BITS (65536) store
// addresses with busy high. Results cannot be stalled.
module direct_mapped_writeback_cache_core
    import dmwc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t response
);

    state_t state_reg, state_next;

    req_t                 req_reg, req_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [TAG_BITS-1:0]  tags_reg [NUM_LINES];
    logic [NUM_LINES-1:0] dirty_reg;
    logic                 hit_reg, hit_next;
    logic                 wdirty_reg, wdirty_next;
    logic [DATA_BITS-1:0] byte_reg, byte_next;
    rsp_t                 resp_reg, resp_next;
    logic                 done_reg, done_next;

    logic [OFF_BITS-1:0]  req_off;
    logic [IDX_BITS-1:0]  req_idx;
    logic [TAG_BITS-1:0]  req_tag;
    logic                 lookup_hit;
    logic [CNT_BITS-1:0]  cnt_m1;
    logic                 cnt_end;

    logic                 tag_we;
    logic                 dirty_we;

    logic                 c_we;
    logic [CACHE_AW-1:0]  c_waddr;
    logic [DATA_BITS-1:0] c_wdata;
    logic [CACHE_AW-1:0]  c_raddr;
    logic [DATA_BITS-1:0] c_rdata;

    logic                 s_we;
    logic [ADDR_BITS-1:0] s_waddr;
    logic [DATA_BITS-1:0] s_wdata;
    logic [ADDR_BITS-1:0] s_raddr;
    logic [DATA_BITS-1:0] s_rdata;

    assign req_off    = req_reg.address[OFF_BITS-1:0];
    assign req_idx    = req_reg.address[CACHE_AW-1:OFF_BITS];
    assign req_tag    = req_reg.address[ADDR_BITS-1:CACHE_AW];
    assign lookup_hit = (tags_reg[req_idx] == req_tag);
    assign cnt_m1     = cnt_reg - CNT_BITS'(1);
    assign cnt_end    = (cnt_reg == CNT_BITS'(LINE_BYTES));

    dmwc_ram #(
        .WIDTH(DATA_BITS),
        .DEPTH(CACHE_DEPTH)
    ) u_cache_ram (
        .clk  (clk),
        .we   (c_we),
        .waddr(c_waddr),
        .wdata(c_wdata),
        .raddr(c_raddr),
        .rdata(c_rdata)
    );

    dmwc_ram #(
        .WIDTH(DATA_BITS),
        .DEPTH(STORE_DEPTH)
    ) u_store_ram (
        .clk  (clk),
        .we   (s_we),
        .waddr(s_waddr),
        .wdata(s_wdata),
        .raddr(s_raddr),
        .rdata(s_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == {ADDR_BITS{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (lookup_hit)
                begin
                    state_next = (req_reg.op == OP_WRITE) ? S_IDLE : S_READ;
                end
                else if (dirty_reg[req_idx])
                begin
                    state_next = S_EVICT;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            S_EVICT:
            begin
                if (cnt_end)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (cnt_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory port control
    always_comb
    begin
        c_we    = 1'b0;
        c_waddr = {req_idx, req_off};
        c_wdata = req_reg.data;
        c_raddr = {req_idx, req_off};
        s_we    = 1'b0;
        s_waddr = {tags_reg[req_idx], req_idx, cnt_m1[OFF_BITS-1:0]};
        s_wdata = c_rdata;
        s_raddr = {req_reg.address[ADDR_BITS-1:OFF_BITS], cnt_reg[OFF_BITS-1:0]};
        case (state_reg)
            S_CLEAR:
            begin
                c_we    = 1'b1;
                c_waddr = clr_reg[CACHE_AW-1:0];
                c_wdata = '0;
                s_we    = 1'b1;
                s_waddr = clr_reg;
                s_wdata = '0;
            end
            S_LOOKUP:
            begin
                c_we = lookup_hit && (req_reg.op == OP_WRITE);
            end
            S_EVICT:
            begin
                // read byte k while the byte read last cycle goes out
                c_raddr = {req_idx, cnt_reg[OFF_BITS-1:0]};
                s_we    = (cnt_reg != '0);
            end
            S_FILL:
            begin
                c_we    = (cnt_reg != '0);
                c_waddr = {req_idx, cnt_m1[OFF_BITS-1:0]};
                // merge the store byte of a write miss into the fill
                if ((req_reg.op == OP_WRITE) && (cnt_m1[OFF_BITS-1:0] == req_off))
                begin
                    c_wdata = req_reg.data;
                end
                else
                begin
                    c_wdata = s_rdata;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Datapath register updates
    always_comb
    begin
        req_next    = req_reg;
        cnt_next    = cnt_reg;
        clr_next    = clr_reg;
        hit_next    = hit_reg;
        wdirty_next = wdirty_reg;
        byte_next   = byte_reg;
        resp_next   = resp_reg;
        done_next   = 1'b0;
        tag_we      = 1'b0;
        dirty_we    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + ADDR_BITS'(1);
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                end
            end
            S_LOOKUP:
            begin
                hit_next    = lookup_hit;
                wdirty_next = dirty_reg[req_idx];
                cnt_next    = '0;
                dirty_we    = lookup_hit && (req_reg.op == OP_WRITE);
            end
            S_READ:
            begin
                done_next           = 1'b1;
                resp_next.read_byte = c_rdata;
                resp_next.hit       = hit_reg;
                resp_next.line_dirty = wdirty_reg;
            end
            S_EVICT:
            begin
                cnt_next = cnt_end ? '0 : cnt_reg + CNT_BITS'(1);
            end
            S_FILL:
            begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if ((cnt_reg != '0) && (cnt_m1[OFF_BITS-1:0] == req_off))
                begin
                    byte_next = s_rdata;
                end
                if (cnt_end)
                begin
                    tag_we   = 1'b1;
                    dirty_we = 1'b1;
                    if (req_reg.op == OP_READ)
                    begin
                        done_next = 1'b1;
                        // last byte lands this cycle, so take it straight
                        if (cnt_m1[OFF_BITS-1:0] == req_off)
                        begin
                            resp_next.read_byte = s_rdata;
                        end
                        else
                        begin
                            resp_next.read_byte = byte_reg;
                        end
                        resp_next.hit        = hit_reg;
                        resp_next.line_dirty = wdirty_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            dirty_reg <= '0;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                tags_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (tag_we)
            begin
                tags_reg[req_idx] <= req_tag;
            end
            if (dirty_we)
            begin
                dirty_reg[req_idx] <= req_reg.op;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        hit_reg    <= hit_next;
        wdirty_reg <= wdirty_next;
        byte_reg   <= byte_next;
        resp_reg   <= resp_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign response = resp_reg;

    // A beat never produces a result on the cycle right after acceptance.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobe right after accept");

    // Result strobes are never back to back.
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result strobes");

    // A finished fill installs the requested tag.
    a_fill_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && cnt_end) |=> (tags_reg[req_idx] == req_tag))
        else $error("line tag not updated by fill");

    // A write hit leaves its line dirty.
    a_write_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP && lookup_hit && req_reg.op == OP_WRITE)
        |=> dirty_reg[req_idx])
        else $error("write hit did not mark line dirty");

    // A miss on a dirty line always writes back before refilling.
    a_evict_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP && !lookup_hit && dirty_reg[req_idx])
        |=> (state_reg == S_EVICT))
        else $error("dirty victim skipped write-back");

endmodule

FILE: hdl/dmwc_ram.sv
// ----------------------------------------------------------------------------
// dmwc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dmwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/sv/direct_mapped_writeback_cache_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_core_test
// Self-checking bench for the direct-mapped write-back byte cache. A local
// model of the cache, its tags, dirty bits and backing store predicts every
// read beat; a monitor compares each response strobe against the oldest
// prediction. Directed cases cover reset contents, write allocation and
// dirty victims; line sweeps and random traffic, gapped or gapless, follow.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_core_test;
    import dmwc_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int MAX_GAP       = 13;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    rsp_t response;

    // shadow copy of the cache and the memory behind it
    logic [DATA_BITS-1:0] shadow_bytes [CACHE_DEPTH];
    logic [TAG_BITS-1:0]  shadow_tags  [NUM_LINES];
    logic                 shadow_dirty [NUM_LINES];
    logic [DATA_BITS-1:0] shadow_store [STORE_DEPTH];

    rsp_t pending_reads [$];
    bit   gapless;
    int   failures;
    int   cycle_count;
    int   reads_sent;
    int   writes_sent;
    int   line_fills;
    int   writebacks;
    int   reads_checked;

    direct_mapped_writeback_cache_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // Apply one access to the shadow state; return 1 with the expected
    // response for a read, 0 for a write.
    function automatic bit cache_access(input req_t item, output rsp_t reply);
        logic [OFF_BITS-1:0] off;
        logic [IDX_BITS-1:0] idx;
        logic [TAG_BITS-1:0] tag;
        logic                was_hit;
        logic                was_dirty;
        logic [OFF_BITS-1:0] i;
        off       = item.address[OFF_BITS-1:0];
        idx       = item.address[OFF_BITS +: IDX_BITS];
        tag       = item.address[ADDR_BITS-1 -: TAG_BITS];
        was_hit   = (shadow_tags[idx] == tag);
        was_dirty = shadow_dirty[idx];
        reply     = '0;
        if (!was_hit)
        begin
            line_fills++;
            if (was_dirty)
            begin
                writebacks++;
                for (int k = 0; k < LINE_BYTES; k++)
                begin
                    i = OFF_BITS'(k);
                    shadow_store[{shadow_tags[idx], idx, i}] = shadow_bytes[{idx, i}];
                end
            end
            for (int k = 0; k < LINE_BYTES; k++)
            begin
                i = OFF_BITS'(k);
                shadow_bytes[{idx, i}] = shadow_store[{tag, idx, i}];
            end
            shadow_tags[idx] = tag;
        end
        if (item.op == OP_WRITE)
        begin
            shadow_bytes[{idx, off}] = item.data;
            shadow_dirty[idx] = 1'b1;
            return 1'b0;
        end
        if (!was_hit)
            shadow_dirty[idx] = 1'b0;
        reply.read_byte  = shadow_bytes[{idx, off}];
        reply.hit        = was_hit;
        reply.line_dirty = was_dirty;
        return 1'b1;
    endfunction

    // Present one beat and hold it until the core takes it.
    task automatic send_beat(input req_t item);
        int   gap;
        rsp_t reply;
        gap = gapless ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (cache_access(item, reply))
        begin
            pending_reads.push_back(reply);
            reads_sent++;
        end
        else
            writes_sent++;
    endtask

    task automatic send_op(input logic op, input logic [ADDR_BITS-1:0] address,
                           input logic [DATA_BITS-1:0] data);
        req_t item;
        item.op      = op;
        item.address = address;
        item.data    = data;
        send_beat(item);
    endtask

    // Drop start, wait out every read, then let a trailing write miss finish.
    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly a few tags over a few lines so that lines conflict and get
    // reused; now and then a fully random address.
    function automatic logic [ADDR_BITS-1:0] pick_address();
        logic [TAG_BITS-1:0] tag;
        logic [IDX_BITS-1:0] idx;
        logic [OFF_BITS-1:0] off;
        if ($urandom_range(0, 9) == 0)
            return ADDR_BITS'($urandom_range(0, STORE_DEPTH - 1));
        tag = TAG_BITS'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1)
            tag = ~tag;
        if ($urandom_range(0, 1) == 1)
            idx = IDX_BITS'($urandom_range(0, 3));
        else
            idx = IDX_BITS'($urandom_range(0, NUM_LINES - 1));
        off = OFF_BITS'($urandom_range(0, LINE_BYTES - 1));
        return {tag, idx, off};
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_op($urandom_range(0, 1) ? OP_WRITE : OP_READ, pick_address(),
                    DATA_BITS'($urandom_range(0, 255)));
    endtask

    task automatic test_reset_contents();
        send_op(OP_READ,  16'h0000, 8'h00);
        send_op(OP_READ,  16'h00ff, 8'hff);
        send_op(OP_WRITE, 16'h0000, 8'hff);
        send_op(OP_READ,  16'h0000, 8'h00);
    endtask

    task automatic test_write_allocate();
        send_op(OP_WRITE, 16'hffff, 8'h80);
        send_op(OP_READ,  16'hffff, 8'h00);
        send_op(OP_WRITE, 16'h8000, 8'h00);
        send_op(OP_WRITE, 16'h8001, 8'h7f);
        send_op(OP_READ,  16'h8001, 8'h00);
        send_op(OP_WRITE, 16'h5555, 8'h55);
        send_op(OP_WRITE, 16'haaaa, 8'haa);
    endtask

    task automatic test_victim_writeback();
        send_op(OP_READ,  16'h00f8, 8'h00);
        send_op(OP_READ,  16'hffff, 8'h00);
        send_op(OP_WRITE, 16'h0107, 8'h01);
        send_op(OP_READ,  16'h0000, 8'h00);
        send_op(OP_READ,  16'h0107, 8'h00);
        send_op(OP_READ,  16'h0001, 8'hff);
        send_op(OP_READ,  16'h5555, 8'h00);
        send_op(OP_READ,  16'haaaa, 8'h00);
        send_op(OP_READ,  16'h55d5, 8'h00);
        send_op(OP_READ,  16'h5555, 8'h00);
    endtask

    task automatic test_drain_pause();
        send_random(12);
        wait_for_results();
        send_random(12);
    endtask

    // Fill a whole line, then read it back, possibly evicting it in between.
    task automatic test_line_sweeps(input int count);
        logic [TAG_BITS-1:0] tag;
        logic [IDX_BITS-1:0] idx;
        logic [OFF_BITS-1:0] off;
        for (int n = 0; n < count; n++)
        begin
            tag = TAG_BITS'($urandom_range(0, 255));
            idx = IDX_BITS'($urandom_range(0, NUM_LINES - 1));
            for (int k = 0; k < LINE_BYTES; k++)
            begin
                off = OFF_BITS'(k);
                send_op(OP_WRITE, {tag, idx, off}, DATA_BITS'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 1)
                send_op(OP_READ, {~tag, idx, {OFF_BITS{1'b0}}}, 8'h00);
            for (int k = 0; k < LINE_BYTES; k++)
            begin
                off = OFF_BITS'($urandom_range(0, LINE_BYTES - 1));
                send_op(OP_READ, {tag, idx, off}, DATA_BITS'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_mix(input int count);
        gapless = 1'b0;
        send_random(count);
    endtask

    task automatic test_gapless_burst(input int count);
        gapless = 1'b1;
        send_random(count);
        gapless = 1'b0;
    endtask

    // Score every response strobe against the oldest prediction.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("response beat with no read outstanding: %h", response);
                failures++;
            end
            else
            begin
                want = pending_reads.pop_front();
                reads_checked++;
                if (response.read_byte !== want.read_byte)
                begin
                    $error("read_byte: expected %h, got %h", want.read_byte,
                           response.read_byte);
                    failures++;
                end
                if (response.hit !== want.hit)
                begin
                    $error("hit: expected %b, got %b", want.hit, response.hit);
                    failures++;
                end
                if (response.line_dirty !== want.line_dirty)
                begin
                    $error("line_dirty: expected %b, got %b", want.line_dirty,
                           response.line_dirty);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL direct_mapped_writeback_cache_core");
        $finish;
    end

    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        gapless       = 1'b0;
        failures      = 0;
        reads_sent    = 0;
        writes_sent   = 0;
        line_fills    = 0;
        writebacks    = 0;
        reads_checked = 0;
        foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
        foreach (shadow_tags[i])  shadow_tags[i]  = '0;
        foreach (shadow_dirty[i]) shadow_dirty[i] = 1'b0;
        foreach (shadow_store[i]) shadow_store[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_contents();
        test_write_allocate();
        test_victim_writeback();
        test_drain_pause();
        test_line_sweeps(8);
        test_random_mix(170);
        test_gapless_burst(80);
        test_random_mix(40);
        wait_for_results();

        $display("Covered %0d reads and %0d writes, %0d responses checked.",
                 reads_sent, writes_sent, reads_checked);
        $display("Line fills: %0d, dirty victims written back: %0d.",
                 line_fills, writebacks);
        if (failures == 0)
            $display("PASS direct_mapped_writeback_cache_core");
        else
            $display("FAIL direct_mapped_writeback_cache_core");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/dmwc_pkg.sv
hdl/dmwc_ram.sv
hdl/direct_mapped_writeback_cache_core.sv
tb/sv/direct_mapped_writeback_cache_core_test.sv
